/* design/hcbd_pkg.sv */
// Shared types, byte codes and the hex digit decoder for the chunked body decoder.
// No dependencies; used by hcbd_core and http_chunked_body_decoder.
`default_nettype none

package hcbd_pkg;

    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hcbd_hex_t;

    // One result per input byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       chunk_end;
        logic       body_end;
        logic       truncated;
        logic       size_error;
    } hcbd_result_t;

    function automatic hcbd_hex_t hex_decode(input logic [7:0] b);
        hcbd_hex_t h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
            h.value = 4'(b[2:0] + 3'd1) + 4'd8;
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

/* design/hcbd_core.sv */
// Chunk framing state and the per-byte result logic of the chunked body decoder.
// Depends on hcbd_pkg. State advances only when a byte steps through.
`default_nettype none

module hcbd_core #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    output hcbd_pkg::hcbd_result_t   result
);
    import hcbd_pkg::*;

    typedef enum logic [2:0] {
        PH_SIZE_WS = 3'd0,
        PH_DIGITS  = 3'd1,
        PH_EXT     = 3'd2,
        PH_DATA    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERR     = 3'd6
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_accum_reg, size_accum_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic [SIZE_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic [1:0]           skip_left_reg, skip_left_next;

    hcbd_hex_t hex;
    logic      is_ws;
    logic      line_end;

    assign hex      = hex_decode(in_byte);
    assign is_ws    = (in_byte == CHAR_SP) || (in_byte == CHAR_TAB);
    assign line_end = (in_byte == CHAR_LF) && prev_cr_reg;

    always_comb begin
        phase_next      = phase_reg;
        size_accum_next = size_accum_reg;
        digit_seen_next = digit_seen_reg;
        prev_cr_next    = prev_cr_reg;
        bytes_left_next = bytes_left_reg;
        skip_left_next  = skip_left_reg;
        result          = '0;

        unique case (phase_reg)
            PH_SIZE_WS, PH_DIGITS, PH_EXT: begin
                if (phase_reg == PH_SIZE_WS && is_ws) begin
                    phase_next = PH_SIZE_WS;
                end else if (phase_reg != PH_EXT && hex.is_hex) begin
                    if (size_accum_reg[SIZE_BITS-1 -: 4] != 4'd0) begin
                        phase_next = PH_ERR;
                    end else begin
                        size_accum_next = {size_accum_reg[SIZE_BITS-5:0], hex.value};
                        digit_seen_next = 1'b1;
                        phase_next      = PH_DIGITS;
                    end
                end else if (line_end) begin
                    prev_cr_next = 1'b0;
                    if (!digit_seen_reg || size_accum_reg == '0) begin
                        phase_next = PH_DONE;
                    end else begin
                        bytes_left_next = size_accum_reg;
                        phase_next      = PH_DATA;
                    end
                end else begin
                    prev_cr_next = (in_byte == CHAR_CR);
                    phase_next   = PH_EXT;
                end
            end
            PH_DATA: begin
                result.out_byte  = in_byte;
                result.out_valid = 1'b1;
                if (bytes_left_reg != '0) begin
                    bytes_left_next = bytes_left_reg - SIZE_BITS'(1);
                end
                if (bytes_left_next == '0) begin
                    result.chunk_end = 1'b1;
                    phase_next       = PH_SKIP;
                    skip_left_next   = 2'd2;
                end
            end
            PH_SKIP: begin
                if (skip_left_reg != 2'd0) begin
                    skip_left_next = skip_left_reg - 2'd1;
                end
                if (skip_left_next == 2'd0) begin
                    phase_next      = PH_SIZE_WS;
                    size_accum_next = '0;
                    digit_seen_next = 1'b0;
                    prev_cr_next    = 1'b0;
                end
            end
            PH_DONE, PH_ERR: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = PH_DONE;
            end
        endcase

        result.size_error = (phase_next == PH_ERR);
        result.body_end   = in_last;
        if (in_last) begin
            result.truncated = (phase_next == PH_DATA) && (bytes_left_next != '0);
            phase_next       = PH_SIZE_WS;
            size_accum_next  = '0;
            digit_seen_next  = 1'b0;
            prev_cr_next     = 1'b0;
            bytes_left_next  = '0;
            skip_left_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SIZE_WS;
            size_accum_reg <= '0;
            digit_seen_reg <= 1'b0;
            prev_cr_reg    <= 1'b0;
            bytes_left_reg <= '0;
            skip_left_reg  <= 2'd0;
        end else if (step) begin
            phase_reg      <= phase_next;
            size_accum_reg <= size_accum_next;
            digit_seen_reg <= digit_seen_next;
            prev_cr_reg    <= prev_cr_next;
            bytes_left_reg <= bytes_left_next;
            skip_left_reg  <= skip_left_next;
        end
    end

    // Payload phase always owes at least one byte
    a_data_owes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("payload phase with no bytes owed");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_last |=> phase_reg == PH_SIZE_WS && size_accum_reg == '0
                            && !digit_seen_reg)
        else $error("state not restarted after last byte");

    a_cend_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.chunk_end |=> phase_reg == PH_SKIP || phase_reg == PH_SIZE_WS)
        else $error("chunk end did not lead to skip");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.size_error && !in_last |=> phase_reg == PH_ERR)
        else $error("size error not held");

endmodule

`default_nettype wire

/* design/http_chunked_body_decoder.sv */
// Top level of the chunked body decoder: input register, hcbd_core, result register.
// Depends on hcbd_pkg and hcbd_core.
//
//  channel | dir | tdata          | tuser                                      | tlast
//  s_      | in  | [7:0] in_byte  | -                                          | in_last
//  m_      | out | [7:0] out_byte | [0] out_valid [1] chunk_end [2] truncated  | body_end
//          |     |                | [3] size_error                             |
//
// One byte per cycle sustained while m_tready stays high; one result transfer per input
// transfer (input register, then result register after the single-pass framing logic).
// aresetn is synchronous, active low; it clears both valids and the framing state.
// A stalled result holds in the result register while the input register still takes
// one more byte; ready flows back through both stages in the same cycle.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] out_byte
    output      logic [3:0] m_tuser,   // [0] out_valid, [1] chunk_end, [2] truncated, [3] size_error
    output      logic       m_tlast
);
    import hcbd_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    hcbd_result_t out_reg;
    hcbd_result_t result;
    logic         out_ready;
    logic         step;

    assign out_ready = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    hcbd_core #(
        .SIZE_BITS (SIZE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (step) begin
                in_valid_reg <= 1'b0;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.size_error, out_reg.truncated, out_reg.chunk_end,
                       out_reg.out_valid};
    assign m_tlast  = out_reg.body_end;

endmodule

`default_nettype wire
